// File: design/cas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cas_pkg: shared definitions for the cave automaton step unit
// Geometry limits, register map, result record and the per-cell rule.
// ----------------------------------------------------------------------------
package cas_pkg;

   localparam int MAX_WIDTH  = 62;
   localparam int MAX_HEIGHT = 256;

   localparam int COL_W = 6;
   localparam int ROW_W = 8;
   localparam int HGT_W = 9;
   localparam int THR_W = 4;

   localparam logic [COL_W-1:0] WIDTH_MIN  = COL_W'(3);
   localparam logic [COL_W-1:0] WIDTH_MAX  = COL_W'(MAX_WIDTH);
   localparam logic [HGT_W-1:0] HEIGHT_MIN = HGT_W'(3);
   localparam logic [HGT_W-1:0] HEIGHT_MAX = HGT_W'(MAX_HEIGHT);

   // result queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = FIFO_AW + 1;
   localparam logic [FIFO_CW-1:0] FIFO_FULL     = FIFO_CW'(FIFO_DEPTH);
   localparam logic [FIFO_CW-1:0] FIFO_ROOM_LIM = FIFO_CW'(FIFO_DEPTH - 4);

   // register map, index = paddr[3:2]
   localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SURVIVE_MIN = 2'd2;
   localparam logic [1:0] REG_BIRTH_ABOVE = 2'd3;

   typedef struct packed {
      logic             next_is_wall;
      logic [COL_W-1:0] cell_column;
      logic [ROW_W-1:0] cell_row;
      logic             frame_end;
   } rsp_item_type;

   function automatic logic [3:0] ones3(input logic [2:0] v);
      return {3'b000, v[0]} + {3'b000, v[1]} + {3'b000, v[2]};
   endfunction

   function automatic logic near_pos(input logic [9:0] a, input logic [9:0] b);
      return ((a + 10'd1) >= b) && (a <= (b + 10'd1));
   endfunction

   // Column vectors: bit0 top row, bit1 middle row, bit2 bottom row.
   // Out-of-grid neighbors count as walls.
   function automatic logic cell_next(
      input logic [2:0]       lcol,
      input logic [2:0]       mcol,
      input logic [2:0]       rcol,
      input logic             lout,
      input logic             rout,
      input logic             tout,
      input logic             bout,
      input logic [COL_W-1:0] col,
      input logic [ROW_W-1:0] row,
      input logic [COL_W-1:0] wd,
      input logic [HGT_W-1:0] ht,
      input logic [THR_W-1:0] surv,
      input logic [THR_W-1:0] birth
   );
      logic [2:0] brd_m;
      logic [2:0] lm;
      logic [2:0] mm;
      logic [2:0] rm;
      logic [3:0] cnt;
      logic       nxt;
      logic       col_hit;
      logic       row_hit;
      brd_m   = {bout, 1'b0, tout};
      lm      = lout ? 3'b111 : (lcol | brd_m);
      rm      = rout ? 3'b111 : (rcol | brd_m);
      mm      = mcol | brd_m;
      cnt     = ones3(lm) + ones3(rm) + {3'b000, mm[0]} + {3'b000, mm[2]};
      nxt     = mm[1] ? (cnt >= surv) : (cnt > birth);
      col_hit = near_pos({4'b0000, col}, {5'b00000, wd[COL_W-1:1]});
      row_hit = near_pos({2'b00, row}, {1'b0, ht} - 10'd3) ||
                near_pos({2'b00, row}, 10'd2);
      if (col_hit && row_hit) begin
         nxt = 1'b0;
      end
      return nxt;
   endfunction

endpackage

// File: design/cave_automaton_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cave_automaton_step_unit: one generation of the wall/empty cave automaton
// Raster cell stream in, updated cells out one row late; the last cell of
// the grid flushes the final row from the line memory.
// ----------------------------------------------------------------------------
//   channel | ports                         | direction | moves
//   req     | req_valid/ready, req_is_wall  | in        | one cell per request
//   rsp     | rsp_valid/ready, rsp_*        | out       | one updated cell
//   csr     | csr_p*                        | in/out    | APB register access
//
// Takes one request per cycle while results drain at one per cycle. A row's
// last cell yields two results and the next row's first cell none, so at full
// output rate the result queue (8 deep) never holds requests off; it does so
// only while it holds more than four results.
// The frame's last cell starts a flush: requests are held off while the flush
// primes the line memory read and then sweeps it to produce the bottom row,
// and a full queue stalls that sweep.
// Each request is registered into the update stage, whose results enter the queue.
// Reset is synchronous; the line memory needs no clearing pass.
module cave_automaton_step_unit
   import cas_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_is_wall,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_next_is_wall,
   output logic [COL_W-1:0] rsp_cell_column,
   output logic [ROW_W-1:0] rsp_cell_row,
   output logic             rsp_frame_end,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic [1:0] FL_IDLE   = 2'd0;
   localparam logic [1:0] FL_PRIME0 = 2'd1;
   localparam logic [1:0] FL_PRIME1 = 2'd2;
   localparam logic [1:0] FL_RUN    = 2'd3;

   // configuration
   logic [COL_W-1:0] cfg_width_ff;
   logic [HGT_W-1:0] cfg_height_ff;
   logic [THR_W-1:0] cfg_survive_ff;
   logic [THR_W-1:0] cfg_birth_ff;
   logic             csr_wr;
   logic             geom_wr;
   logic [COL_W-1:0] w_eff;
   logic [HGT_W-1:0] h_eff;
   logic [COL_W-1:0] w_m1;
   logic [ROW_W-1:0] h_m1;

   // position and request stage
   logic [COL_W-1:0] col_cnt_ff;
   logic [ROW_W-1:0] row_cnt_ff;
   logic [COL_W-1:0] c_cur;
   logic [ROW_W-1:0] r_cur;
   logic             row_end;
   logic             frame_last;
   logic             acc;

   // line memory: bit1 row above, bit0 two rows above
   logic [1:0]       line_mem [MAX_WIDTH];
   logic [1:0]       rd_ff;
   logic             rd_en;
   logic [COL_W-1:0] rd_addr;

   // update stage
   logic             b_valid_ff;
   logic             b_bit_ff;
   logic [COL_W-1:0] b_c_ff;
   logic [ROW_W-1:0] b_r_ff;
   logic [5:0]       window_ff;
   logic [5:0]       window_in;
   logic [2:0]       col3;
   logic [2:0]       wl;
   logic [2:0]       wm;
   logic             b_row_end;
   logic             b_final;
   logic             emit0;
   logic             emit1;
   rsp_item_type     res0;
   rsp_item_type     res1;

   // flush sweep
   logic [1:0]       fl_state_ff;
   logic [1:0]       fl_state_in;
   logic [COL_W-1:0] fl_x_ff;
   logic [1:0]       fl_left_ff;
   logic [1:0]       fl_mid_ff;
   logic             fl_step;
   logic             fl_last;
   logic [COL_W:0]   fl_x_p2;
   rsp_item_type     fres;

   // result queue
   rsp_item_type       fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_CW-1:0] fifo_cnt_ff;
   logic               push0;
   logic               push1;
   rsp_item_type       push0_data;
   logic               pop;
   logic [FIFO_CW-1:0] push_n;
   rsp_item_type       head;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign geom_wr    = csr_wr && ((csr_paddr[3:2] == REG_GRID_WIDTH) ||
                                  (csr_paddr[3:2] == REG_GRID_HEIGHT));

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff   <= COL_W'(62);
         cfg_height_ff  <= HGT_W'(32);
         cfg_survive_ff <= THR_W'(4);
         cfg_birth_ff   <= THR_W'(4);
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_GRID_WIDTH:  cfg_width_ff   <= csr_pwdata[COL_W-1:0];
            REG_GRID_HEIGHT: cfg_height_ff  <= csr_pwdata[HGT_W-1:0];
            REG_SURVIVE_MIN: cfg_survive_ff <= csr_pwdata[THR_W-1:0];
            REG_BIRTH_ABOVE: cfg_birth_ff   <= csr_pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_GRID_WIDTH:  csr_prdata = {{(32-COL_W){1'b0}}, cfg_width_ff};
         REG_GRID_HEIGHT: csr_prdata = {{(32-HGT_W){1'b0}}, cfg_height_ff};
         REG_SURVIVE_MIN: csr_prdata = {{(32-THR_W){1'b0}}, cfg_survive_ff};
         REG_BIRTH_ABOVE: csr_prdata = {{(32-THR_W){1'b0}}, cfg_birth_ff};
         default:         csr_prdata = 32'd0;
      endcase
   end

   assign w_eff = (cfg_width_ff < WIDTH_MIN) ? WIDTH_MIN :
                  (cfg_width_ff > WIDTH_MAX) ? WIDTH_MAX : cfg_width_ff;
   assign h_eff = (cfg_height_ff < HEIGHT_MIN) ? HEIGHT_MIN :
                  (cfg_height_ff > HEIGHT_MAX) ? HEIGHT_MAX : cfg_height_ff;
   assign w_m1  = w_eff - COL_W'(1);
   assign h_m1  = ROW_W'(h_eff - HGT_W'(1));

   // ---------------- request side ----------------
   assign req_ready  = (fl_state_ff == FL_IDLE) && (fifo_cnt_ff <= FIFO_ROOM_LIM);
   assign acc        = req_valid && req_ready;
   assign c_cur      = (col_cnt_ff > w_m1) ? '0 : col_cnt_ff;
   assign r_cur      = (row_cnt_ff > h_m1) ? '0 : row_cnt_ff;
   assign row_end    = (c_cur == w_m1);
   assign frame_last = row_end && (r_cur == h_m1);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= acc;
         if (geom_wr) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= '0;
         end else if (acc) begin
            if (frame_last) begin
               col_cnt_ff <= '0;
               row_cnt_ff <= '0;
            end else if (row_end) begin
               col_cnt_ff <= '0;
               row_cnt_ff <= r_cur + ROW_W'(1);
            end else begin
               col_cnt_ff <= c_cur + COL_W'(1);
               row_cnt_ff <= r_cur;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         b_bit_ff <= req_is_wall;
         b_c_ff   <= c_cur;
         b_r_ff   <= r_cur;
      end
   end

   // ---------------- line memory ----------------
   assign fl_x_p2 = {1'b0, fl_x_ff} + (COL_W+1)'(2);

   always_comb begin
      case (fl_state_ff)
         FL_IDLE: begin
            rd_en   = acc;
            rd_addr = c_cur;
         end
         FL_PRIME0: begin
            rd_en   = 1'b1;
            rd_addr = COL_W'(0);
         end
         FL_PRIME1: begin
            rd_en   = 1'b1;
            rd_addr = COL_W'(1);
         end
         FL_RUN: begin
            rd_en   = fl_step && (fl_x_p2 < {1'b0, w_eff});
            rd_addr = fl_x_p2[COL_W-1:0];
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = '0;
         end
      endcase
   end

   // write-back of the update stage never hits the address read in the same cycle
   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         line_mem[b_c_ff] <= {b_bit_ff, rd_ff[1]};
      end
      if (rd_en) begin
         rd_ff <= line_mem[rd_addr];
      end
   end

   // ---------------- update stage ----------------
   assign col3      = {b_bit_ff, rd_ff[1], rd_ff[0]};
   assign wl        = window_ff[5:3];
   assign wm        = window_ff[2:0];
   assign b_row_end = (b_c_ff == w_m1);
   assign b_final   = b_row_end && (b_r_ff == h_m1);
   assign emit0     = b_valid_ff && (b_r_ff != '0) && (b_c_ff != '0);
   assign emit1     = b_valid_ff && (b_r_ff != '0) && b_row_end;

   always_comb begin
      res0.next_is_wall = cell_next(wl, wm, col3, (b_c_ff == COL_W'(1)), 1'b0,
                                    (b_r_ff == ROW_W'(1)), 1'b0,
                                    b_c_ff - COL_W'(1), b_r_ff - ROW_W'(1),
                                    w_eff, h_eff, cfg_survive_ff, cfg_birth_ff);
      res0.cell_column  = b_c_ff - COL_W'(1);
      res0.cell_row     = b_r_ff - ROW_W'(1);
      res0.frame_end    = 1'b0;
      res1.next_is_wall = cell_next(wm, col3, 3'b000, 1'b0, 1'b1,
                                    (b_r_ff == ROW_W'(1)), 1'b0,
                                    b_c_ff, b_r_ff - ROW_W'(1),
                                    w_eff, h_eff, cfg_survive_ff, cfg_birth_ff);
      res1.cell_column  = b_c_ff;
      res1.cell_row     = b_r_ff - ROW_W'(1);
      res1.frame_end    = 1'b0;
   end

   always_comb begin
      window_in = window_ff;
      if (geom_wr) begin
         window_in = '0;
      end else if (b_valid_ff) begin
         window_in = b_final ? 6'd0 : {wm, col3};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   // ---------------- bottom-row flush ----------------
   assign fl_step = (fl_state_ff == FL_RUN) && (fifo_cnt_ff != FIFO_FULL);
   assign fl_last = (fl_x_ff == w_m1);

   always_comb begin
      fres.next_is_wall = cell_next({1'b0, fl_left_ff}, {1'b0, fl_mid_ff}, {1'b0, rd_ff},
                                    (fl_x_ff == '0), fl_last, 1'b0, 1'b1,
                                    fl_x_ff, h_m1, w_eff, h_eff,
                                    cfg_survive_ff, cfg_birth_ff);
      fres.cell_column  = fl_x_ff;
      fres.cell_row     = h_m1;
      fres.frame_end    = fl_last;
   end

   always_comb begin
      fl_state_in = fl_state_ff;
      case (fl_state_ff)
         FL_IDLE:   if (acc && frame_last) fl_state_in = FL_PRIME0;
         FL_PRIME0: fl_state_in = FL_PRIME1;
         FL_PRIME1: fl_state_in = FL_RUN;
         FL_RUN:    if (fl_step && fl_last) fl_state_in = FL_IDLE;
         default:   fl_state_in = FL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fl_state_ff <= FL_IDLE;
      end else begin
         fl_state_ff <= fl_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fl_state_ff == FL_PRIME1) begin
         fl_mid_ff <= rd_ff;
         fl_x_ff   <= '0;
      end else if (fl_step) begin
         fl_left_ff <= fl_mid_ff;
         fl_mid_ff  <= rd_ff;
         fl_x_ff    <= fl_x_ff + COL_W'(1);
      end
   end

   // ---------------- result queue ----------------
   assign push0      = emit0 || fl_step;
   assign push1      = emit1;
   assign push0_data = fl_step ? fres : res0;
   assign push_n     = FIFO_CW'(push0) + FIFO_CW'(push1);
   assign pop        = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push0) begin
         fifo_ff[wr_ptr_ff] <= push0_data;
      end
      if (push1) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_ff + push_n[FIFO_AW-1:0];
         rd_ptr_ff   <= rd_ptr_ff + FIFO_AW'(pop);
         fifo_cnt_ff <= fifo_cnt_ff + push_n - FIFO_CW'(pop);
      end
   end

   assign head             = fifo_ff[rd_ptr_ff];
   assign rsp_valid        = (fifo_cnt_ff != '0);
   assign rsp_next_is_wall = head.next_is_wall;
   assign rsp_cell_column  = head.cell_column;
   assign rsp_cell_row     = head.cell_row;
   assign rsp_frame_end    = head.frame_end;

`ifndef SYNTHESIS
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= FIFO_FULL)
      else $error("result queue overflow");

   a_mem_no_clash: assert property (@(posedge clock) disable iff (reset)
      !(b_valid_ff && rd_en && (rd_addr == b_c_ff)))
      else $error("line memory read and write-back hit the same column");

   a_frame_end_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> ((rsp_cell_column == w_m1) && (rsp_cell_row == h_m1)))
      else $error("frame end flagged away from the last cell");

   a_flush_after_last: assert property (@(posedge clock) disable iff (reset)
      (acc && frame_last) |=> (fl_state_ff == FL_PRIME0) && b_valid_ff)
      else $error("flush did not start after the last cell");
`endif

endmodule
